>>> src/assert_macros.svh
// Assertion macros used by the decoder RTL.
// Each macro is empty when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("implication check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle check failed");
`else
`define ASSERT_IMPLY(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> src/b64d_pkg.sv
// Types, constants and the alphabet lookup of the Base64 stream decoder.
// No dependencies.
`timescale 1ns / 1ps
package b64d_pkg;

   localparam int TOTAL_BITS = 16;

   localparam logic [5:0] LOWER_BASE = 6'd26;
   localparam logic [5:0] DIGIT_BASE = 6'd52;
   localparam logic [5:0] PLUS_CODE  = 6'd62;
   localparam logic [5:0] SLASH_CODE = 6'd63;
   localparam logic [3:0] NIBBLE_MASK = 4'hF;
   localparam logic [1:0] LOW2_FILL   = 2'h3;

   typedef struct packed {
      logic [7:0] char_code;
      logic       end_of_text;
   } req_item_type;

   typedef struct packed {
      logic [7:0]            out_byte;
      logic                  byte_present;
      logic                  done_res;
      logic                  success;
      logic [TOTAL_BITS-1:0] byte_total;
   } rsp_item_type;

   typedef struct packed {
      logic       ok;
      logic [5:0] value;
   } sextet_type;

   typedef struct packed {
      logic         valid;
      req_item_type item;
   } stage_type;

   function automatic sextet_type sextet_of(input logic [7:0] ch);
      sextet_type s;
      s.ok    = 1'b1;
      s.value = '0;
      if (ch >= 8'h41 && ch <= 8'h5A) begin
         s.value = 6'(ch - 8'h41);
      end else if (ch >= 8'h61 && ch <= 8'h7A) begin
         s.value = 6'(ch - 8'h61) + LOWER_BASE;
      end else if (ch >= 8'h30 && ch <= 8'h39) begin
         s.value = 6'(ch - 8'h30) + DIGIT_BASE;
      end else if (ch == 8'h2B) begin
         s.value = PLUS_CODE;
      end else if (ch == 8'h2F) begin
         s.value = SLASH_CODE;
      end else begin
         s.ok = 1'b0;
      end
      return s;
   endfunction

endpackage

>>> src/b64d_req_if.sv
// Input channel of the decoder: valid, ready and one character item.
// Depends on b64d_pkg.
`timescale 1ns / 1ps
interface b64d_req_if;
   logic                  valid;
   logic                  ready;
   b64d_pkg::req_item_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> src/b64d_rsp_if.sv
// Result channel of the decoder: valid, ready and one result item.
// Depends on b64d_pkg.
`timescale 1ns / 1ps
interface b64d_rsp_if;
   logic                  valid;
   logic                  ready;
   b64d_pkg::rsp_item_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

>>> src/b64d_in_stage.sv
// Input register of the decoder; holds one accepted character item.
// Depends on b64d_pkg and b64d_req_if.
`timescale 1ns / 1ps
module b64d_in_stage (
   input  logic               clock,
   input  logic               reset,
   b64d_req_if.sink           req_chan,
   input  logic               take,
   output b64d_pkg::stage_type stage
);
   import b64d_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   req_item_type item_ff;
   logic         load;

   assign req_chan.ready = !valid_ff || take;
   assign load           = req_chan.valid && req_chan.ready;
   assign valid_in       = load ? 1'b1 : (take ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (load) begin
         item_ff <= req_chan.data;
      end
   end

   assign stage.valid = valid_ff;
   assign stage.item  = item_ff;
endmodule

>>> src/b64d_decode.sv
// Group state, character decode and result register of the decoder.
// Depends on b64d_pkg, b64d_rsp_if and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module b64d_decode #(
   parameter int COUNT_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  b64d_pkg::stage_type stage,
   output logic               take,
   b64d_rsp_if.source         rsp_chan
);
   import b64d_pkg::*;

   typedef enum logic [1:0] {
      PH_FIRST,
      PH_SECOND,
      PH_THIRD,
      PH_FOURTH
   } phase_type;

   phase_type             phase_ff, phase_in;
   logic                  stopped_ff, stopped_in;
   logic [5:0]            prev_ff, prev_in;
   logic                  third_inv_ff, third_inv_in;
   logic [COUNT_BITS-1:0] count_ff, count_in, count_step;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_item_type          rsp_ff, rsp_in;

   sextet_type            sx;
   logic                  emit;
   logic [7:0]            dec_byte;
   logic [1:0]            high_bits;
   logic [TOTAL_BITS-1:0] total;
   logic                  last;

   assign take = stage.valid && (!rsp_valid_ff || rsp_chan.ready);
   assign last = stage.item.end_of_text;
   assign sx   = sextet_of(stage.item.char_code);

   always_comb begin
      phase_in     = phase_ff;
      stopped_in   = stopped_ff;
      prev_in      = prev_ff;
      third_inv_in = third_inv_ff;
      emit         = 1'b0;
      dec_byte     = '0;
      high_bits    = third_inv_ff ? LOW2_FILL : prev_ff[1:0];
      if (!stopped_ff) begin
         case (phase_ff)
            PH_FIRST: begin
               if (!sx.ok) begin
                  stopped_in = 1'b1;
               end else begin
                  prev_in  = sx.value;
                  phase_in = PH_SECOND;
               end
            end
            PH_SECOND: begin
               if (!sx.ok) begin
                  stopped_in = 1'b1;
               end else begin
                  dec_byte = {prev_ff, sx.value[5:4]};
                  emit     = 1'b1;
                  prev_in  = sx.value;
                  phase_in = PH_THIRD;
               end
            end
            PH_THIRD: begin
               if (!sx.ok) begin
                  third_inv_in = 1'b1;
               end else begin
                  dec_byte     = {prev_ff[3:0] & NIBBLE_MASK, sx.value[5:2]};
                  emit         = 1'b1;
                  third_inv_in = 1'b0;
                  prev_in      = sx.value;
               end
               phase_in = PH_FOURTH;
            end
            PH_FOURTH: begin
               if (sx.ok) begin
                  dec_byte = {high_bits, sx.value};
                  emit     = 1'b1;
               end
               third_inv_in = 1'b0;
               prev_in      = '0;
               phase_in     = PH_FIRST;
            end
            default: begin
               phase_in = PH_FIRST;
            end
         endcase
      end
   end

   assign count_step = (emit && !(&count_ff)) ? count_ff + 1'b1 : count_ff;

   generate
      if (COUNT_BITS > TOTAL_BITS) begin : g_sat
         assign total = (|count_step[COUNT_BITS-1:TOTAL_BITS]) ? '1
                                                                : count_step[TOTAL_BITS-1:0];
      end else begin : g_ext
         assign total = TOTAL_BITS'(count_step);
      end
   endgenerate

   always_comb begin
      count_in              = last ? '0 : count_step;
      rsp_in.out_byte       = emit ? dec_byte : '0;
      rsp_in.byte_present   = emit;
      rsp_in.done_res       = last;
      rsp_in.success        = last && (|count_step);
      rsp_in.byte_total     = last ? total : '0;
      if (take) begin
         rsp_valid_in = emit || last;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST;
         stopped_ff   <= 1'b0;
         prev_ff      <= '0;
         third_inv_ff <= 1'b0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            count_ff <= count_in;
            if (last) begin
               phase_ff     <= PH_FIRST;
               stopped_ff   <= 1'b0;
               prev_ff      <= '0;
               third_inv_ff <= 1'b0;
            end else begin
               phase_ff     <= phase_in;
               stopped_ff   <= stopped_in;
               prev_ff      <= prev_in;
               third_inv_ff <= third_inv_in;
            end
         end
      end
      if (take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.data  = rsp_ff;

   `ASSERT_IMPLY(a_empty_only_when_done, clock, reset, rsp_valid_ff && !rsp_ff.byte_present, rsp_ff.done_res)
   `ASSERT_IMPLY(a_success_matches_total, clock, reset, rsp_valid_ff && rsp_ff.done_res, rsp_ff.success == (rsp_ff.byte_total != '0))
   `ASSERT_IMPLY(a_total_only_when_done, clock, reset, rsp_valid_ff && !rsp_ff.done_res, rsp_ff.byte_total == '0 && !rsp_ff.success)
   `ASSERT_NEXT(a_restart_after_last, clock, reset, take && last, phase_ff == PH_FIRST && !stopped_ff && count_ff == '0)
   `ASSERT_IMPLY(a_stopped_no_byte, clock, reset, take && stopped_ff, !emit)
endmodule

>>> src/base64_stream_decoder_core.sv
// Streaming Base64 decoder, standard alphabet, one character per item, one
// input register, decode logic and a result register. A new item is accepted
// every cycle while the result side keeps up, and its result (if any) is
// presented from the result register once the decode logic has taken the item
// from the input register; the one-cycle rate is set by the group state
// update, which closes within the decode stage. Depends on b64d_pkg,
// b64d_req_if, b64d_rsp_if, b64d_in_stage and b64d_decode.
`timescale 1ns / 1ps
module base64_stream_decoder_core #(
   parameter int COUNT_BITS = 16
) (
   input  logic       clock,
   input  logic       reset,
   b64d_req_if.sink   req_chan,
   b64d_rsp_if.source rsp_chan
);
   import b64d_pkg::*;

   stage_type stage;
   logic      take;

   b64d_in_stage u_in_stage (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .take     (take),
      .stage    (stage)
   );

   b64d_decode #(
      .COUNT_BITS (COUNT_BITS)
   ) u_decode (
      .clock    (clock),
      .reset    (reset),
      .stage    (stage),
      .take     (take),
      .rsp_chan (rsp_chan)
   );
endmodule
